// ----- rtl/size_class_pool_allocator_top_macros.svh -----
// Assertion helpers shared by the allocator RTL.
`ifndef SIZE_CLASS_POOL_ALLOCATOR_TOP_MACROS_SVH
`define SIZE_CLASS_POOL_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on clock and held off during reset.
`define SCPA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and held off during reset.
`define SCPA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/scpa_pkg.sv -----
package scpa_pkg;

   localparam int HEAP_CHUNKS     = 256;
   localparam int CHUNK_BYTES     = 4096;
   localparam int NUM_CLASSES     = 8;
   localparam int MIN_CLASS       = 5;
   localparam int MAX_CLASS       = 12;
   localparam int POOL_MAX_SIZE   = 4088;
   localparam int HEADER_BYTES    = 8;

   localparam int CHUNK_SHIFT     = $clog2(CHUNK_BYTES);
   localparam int UNITS_PER_CHUNK = CHUNK_BYTES >> MIN_CLASS;
   localparam int TOTAL_UNITS     = HEAP_CHUNKS * UNITS_PER_CHUNK;
   localparam int UNIT_W          = $clog2(TOTAL_UNITS);
   localparam int LINK_W          = UNIT_W + 1;
   localparam int K_W             = $clog2(UNITS_PER_CHUNK);
   localparam int BRK_W           = $clog2(HEAP_CHUNKS + 1);
   localparam int CLS_IDX_W       = $clog2(NUM_CLASSES);

   localparam logic       CMD_ALLOC = 1'b0;
   localparam logic       CMD_FREE  = 1'b1;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_BULK      = 3'd1;
   localparam logic [2:0] STATUS_EXHAUSTED = 3'd2;
   localparam logic [2:0] STATUS_NOOP      = 3'd3;
   localparam logic [2:0] STATUS_BULK_FREE = 3'd4;

   localparam logic       CSR_HEAP_BASE   = 1'b0;
   localparam logic       CSR_CHUNK_LIMIT = 1'b1;

   typedef logic [UNIT_W-1:0] unit_type;
   // Link word: valid flag in the top bit, unit index below it.
   typedef logic [LINK_W-1:0] link_type;
   typedef logic [3:0]        class_type;

   typedef struct packed {
      logic      en;
      unit_type  addr;
      class_type data;
   } tag_wr_type;

   typedef struct packed {
      logic     en;
      unit_type addr;
      link_type data;
   } link_wr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP,
      ST_FREE,
      ST_CARVE,
      ST_RESP
   } state_type;

   // Class of a request size in the pool range: 5 up to 24 bytes, otherwise
   // the bit length of size plus the header rounding.
   function automatic class_type size_class_of(input logic [19:0] size);
      logic [12:0] v;
      class_type   len;
      v   = 13'(size[11:0]) + 13'd7;
      len = class_type'(MIN_CLASS);
      if (size > 20'd8) begin
         for (int i = 0; i < 13; i++) begin
            if (v[i]) begin
               len = class_type'(i + 1);
            end
         end
      end
      return len;
   endfunction

endpackage

// ----- rtl/scpa_store.sv -----
module scpa_store (
   input  logic                 clock,
   input  scpa_pkg::tag_wr_type  tag_wr,
   input  scpa_pkg::link_wr_type link_wr,
   input  scpa_pkg::unit_type    tag_rd_addr,
   input  scpa_pkg::unit_type    link_rd_addr,
   output scpa_pkg::class_type   tag_rd_ff,
   output scpa_pkg::link_type    link_rd_ff
);
   import scpa_pkg::*;

   // Per-unit class tags and free-list links, one entry per 32-byte unit.
   class_type tag_mem  [TOTAL_UNITS];
   link_type  link_mem [TOTAL_UNITS];

   always_ff @(posedge clock) begin
      if (tag_wr.en) begin
         tag_mem[tag_wr.addr] <= tag_wr.data;
      end
      tag_rd_ff <= tag_mem[tag_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (link_wr.en) begin
         link_mem[link_wr.addr] <= link_wr.data;
      end
      link_rd_ff <= link_mem[link_rd_addr];
   end

endmodule

// ----- rtl/size_class_pool_allocator_top.sv -----
// Each accepted request beat yields one result beat: an immediate answer, a pop, a free, or a
// chunk carve that ends in the pop of the last block carved. Only one item is in flight, so a
// new request beat is taken only after the result of the last has entered the output register,
// later while rsp_tready stalls; a carve tags one unit per cycle.
// Reset is synchronous: all free lists empty, no chunk carved, heap_base 0, chunk_limit 256;
// the unit store is not cleared and needs no clearing pass.
`include "size_class_pool_allocator_top_macros.svh"

module size_class_pool_allocator_top (
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_wdata,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // request_size [19:0], block_address [51:20], zero pad
   input  logic [0:0]  req_tuser,   // cmd

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // user_address [31:0], size_class [35:32], zero pad
   output logic [2:0]  rsp_tuser    // status
);
   import scpa_pkg::*;

   // The allocator keeps a last-in, first-out free list per size class. The list heads sit
   // in a small register file; the link below each block and the class tag of every 32-byte
   // unit live in a synchronous store with a registered read port. An allocate reads the
   // head, fetches its link from the store and writes the link back as the new head. A free
   // fetches the tag of the unit, then pushes the unit by writing the old head into its link.
   // An empty list, heap space permitting, triggers a carve: one unit of the next chunk is tagged
   // per cycle, block bases linked in rising address order; then the last block is handed out.

   state_type   state_ff, state_in;

   logic [31:0] heap_base_ff, heap_base_in;
   logic [8:0]  chunk_limit_ff, chunk_limit_in;

   link_type    class_tops_ff [NUM_CLASSES];
   logic                 tops_we;
   logic [CLS_IDX_W-1:0] tops_wr_idx;
   link_type             tops_wr_data;
   logic [CLS_IDX_W-1:0] tops_rd_idx;
   link_type             tops_rd;

   logic [BRK_W-1:0] break_chunk_ff, break_chunk_in;
   logic [K_W-1:0]   carve_k_ff, carve_k_in;

   // Item in flight.
   class_type   cls_ff, cls_in;
   unit_type    unit_ff, unit_in;

   // Finished result waiting for the output register.
   logic [31:0] res_addr_ff, res_addr_in;
   class_type   res_cls_ff, res_cls_in;
   logic [2:0]  res_status_ff, res_status_in;

   // Output register.
   logic        rsp_tvalid_ff, rsp_tvalid_in;
   logic [31:0] rsp_addr_ff, rsp_addr_in;
   class_type   rsp_cls_ff, rsp_cls_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;

   // Store interface.
   tag_wr_type  tag_wr;
   link_wr_type link_wr;
   unit_type    tag_rd_addr;
   unit_type    link_rd_addr;
   class_type   tag_rd_ff;
   link_type    link_rd_ff;

   // Request decode.
   logic                 req_fire;
   logic                 req_cmd;
   logic [19:0]          req_size;
   logic [31:0]          req_addr;
   logic [31:0]          base32;
   class_type            req_class;
   logic [CLS_IDX_W-1:0] req_cidx;
   logic [31:0]          free_off;
   logic [31:0]          heap_bound;
   unit_type             free_unit;
   logic                 exhausted;

   // Carve arithmetic.
   logic [CLS_IDX_W-1:0] cls_cidx;
   logic [K_W:0]         carve_step;
   logic [K_W-1:0]       carve_mask;
   unit_type             carve_first;
   unit_type             carve_unit;
   unit_type             carve_last;
   logic                 carve_is_base;
   logic                 carve_done;
   link_type             carve_top_after;

   // Free path and address build.
   logic [CLS_IDX_W-1:0] tag_cidx;
   logic                 tag_ok;
   unit_type             addr_unit;
   logic [31:0]          user_addr;

   scpa_store u_store (
      .clock        (clock),
      .tag_wr       (tag_wr),
      .link_wr      (link_wr),
      .tag_rd_addr  (tag_rd_addr),
      .link_rd_addr (link_rd_addr),
      .tag_rd_ff    (tag_rd_ff),
      .link_rd_ff   (link_rd_ff)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_cmd    = req_tuser[0];
   assign req_size   = req_tdata[19:0];
   assign req_addr   = req_tdata[51:20];

   // The heap base register keeps all 32 bits, but the heap is always chunk aligned.
   assign base32     = {heap_base_ff[31:CHUNK_SHIFT], {CHUNK_SHIFT{1'b0}}};

   assign req_class  = size_class_of(req_size);
   assign req_cidx   = CLS_IDX_W'(req_class - class_type'(MIN_CLASS));
   assign free_off   = req_addr - 32'(HEADER_BYTES) - base32;
   assign heap_bound = 32'({break_chunk_ff, {CHUNK_SHIFT{1'b0}}});
   assign free_unit  = free_off[UNIT_W+MIN_CLASS-1:MIN_CLASS];
   assign exhausted  = (16'(break_chunk_ff) >= 16'(chunk_limit_ff)) ||
                       (16'(break_chunk_ff) >= 16'(HEAP_CHUNKS));

   // The list head of the request's class is read in the accept cycle, and the head of the
   // tagged class when a free completes; these never coincide, so one read port serves.
   assign tag_cidx    = CLS_IDX_W'(tag_rd_ff - class_type'(MIN_CLASS));
   assign tops_rd_idx = (state_ff == ST_FREE) ? tag_cidx : req_cidx;
   assign tops_rd     = class_tops_ff[tops_rd_idx];

   // Both store reads are issued straight from the request beat; the registered data is used
   // in the next cycle, in the pop or free state.
   assign link_rd_addr = tops_rd[UNIT_W-1:0];
   assign tag_rd_addr  = free_unit;

   // Carving: blocks of 2^c bytes span 2^(c-5) units. A unit is a block base when its
   // offset within the chunk is a multiple of that step.
   assign cls_cidx      = CLS_IDX_W'(cls_ff - class_type'(MIN_CLASS));
   assign carve_step    = {{K_W{1'b0}}, 1'b1} << cls_cidx;
   assign carve_mask    = K_W'(carve_step - {{K_W{1'b0}}, 1'b1});
   assign carve_first   = UNIT_W'({break_chunk_ff, {K_W{1'b0}}});
   assign carve_unit    = carve_first + UNIT_W'(carve_k_ff);
   assign carve_last    = carve_first + UNIT_W'(UNITS_PER_CHUNK) - UNIT_W'(carve_step);
   assign carve_is_base = ((carve_k_ff & carve_mask) == '0);
   assign carve_done    = (carve_k_ff == K_W'(UNITS_PER_CHUNK - 1));

   // After the carve the last block pushed is popped at once; the block below it becomes
   // the head, unless the chunk held a single block.
   assign carve_top_after = (carve_step == (K_W + 1)'(UNITS_PER_CHUNK)) ? '0 :
                            {1'b1, carve_last - UNIT_W'(carve_step)};

   assign tag_ok = (tag_rd_ff inside {[MIN_CLASS:MAX_CLASS]});

   // One adder forms the user address for both the pop and the carve paths.
   assign addr_unit = (state_ff == ST_CARVE) ? carve_last : unit_ff;
   assign user_addr = base32 + 32'({addr_unit, MIN_CLASS'(HEADER_BYTES)});

   always_comb begin
      heap_base_in   = heap_base_ff;
      chunk_limit_in = chunk_limit_ff;
      if (csr_we) begin
         case (csr_index[0])
            CSR_HEAP_BASE:   heap_base_in   = csr_wdata;
            CSR_CHUNK_LIMIT: chunk_limit_in = csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in       = state_ff;
      break_chunk_in = break_chunk_ff;
      carve_k_in     = carve_k_ff;
      cls_in         = cls_ff;
      unit_in        = unit_ff;
      res_addr_in    = res_addr_ff;
      res_cls_in     = res_cls_ff;
      res_status_in  = res_status_ff;
      tops_we        = 1'b0;
      tops_wr_idx    = cls_cidx;
      tops_wr_data   = link_rd_ff;
      tag_wr         = '0;
      link_wr        = '0;

      // The output register drains independently of the item in flight.
      rsp_tvalid_in  = rsp_tvalid_ff && !rsp_tready;
      rsp_addr_in    = rsp_addr_ff;
      rsp_cls_in     = rsp_cls_ff;
      rsp_status_in  = rsp_status_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               res_addr_in   = '0;
               res_cls_in    = '0;
               res_status_in = STATUS_OK;
               cls_in        = req_class;
               state_in      = ST_RESP;
               if (req_cmd == CMD_ALLOC) begin
                  if (req_size == '0) begin
                     res_status_in = STATUS_NOOP;
                  end else if (req_size > 20'(POOL_MAX_SIZE)) begin
                     res_status_in = STATUS_BULK;
                  end else if (tops_rd[UNIT_W]) begin
                     unit_in  = tops_rd[UNIT_W-1:0];
                     state_in = ST_POP;
                  end else if (exhausted) begin
                     res_status_in = STATUS_EXHAUSTED;
                  end else begin
                     state_in = ST_CARVE;
                  end
               end else begin
                  if (req_addr == '0) begin
                     res_status_in = STATUS_NOOP;
                  end else if (free_off >= heap_bound) begin
                     res_status_in = STATUS_BULK_FREE;
                  end else if (free_off[MIN_CLASS-1:0] != '0) begin
                     res_status_in = STATUS_NOOP;
                  end else begin
                     unit_in  = free_unit;
                     state_in = ST_FREE;
                  end
               end
            end
         end

         ST_POP: begin
            tops_we       = 1'b1;
            tops_wr_idx   = cls_cidx;
            tops_wr_data  = link_rd_ff;
            res_addr_in   = user_addr;
            res_cls_in    = cls_ff;
            res_status_in = STATUS_OK;
            state_in      = ST_RESP;
         end

         ST_FREE: begin
            if (tag_ok) begin
               link_wr.en    = 1'b1;
               link_wr.addr  = unit_ff;
               link_wr.data  = tops_rd;
               tops_we       = 1'b1;
               tops_wr_idx   = tag_cidx;
               tops_wr_data  = {1'b1, unit_ff};
               res_cls_in    = tag_rd_ff;
               res_status_in = STATUS_OK;
            end else begin
               res_cls_in    = '0;
               res_status_in = STATUS_NOOP;
            end
            res_addr_in = '0;
            state_in    = ST_RESP;
         end

         ST_CARVE: begin
            tag_wr.en    = 1'b1;
            tag_wr.addr  = carve_unit;
            tag_wr.data  = carve_is_base ? cls_ff : '0;
            link_wr.en   = carve_is_base;
            link_wr.addr = carve_unit;
            link_wr.data = (carve_k_ff == '0) ? '0 :
                           {1'b1, carve_unit - UNIT_W'(carve_step)};
            carve_k_in   = carve_k_ff + 1'b1;
            if (carve_done) begin
               break_chunk_in = break_chunk_ff + 1'b1;
               tops_we        = 1'b1;
               tops_wr_idx    = cls_cidx;
               tops_wr_data   = carve_top_after;
               res_addr_in    = user_addr;
               res_cls_in     = cls_ff;
               res_status_in  = STATUS_OK;
               state_in       = ST_RESP;
            end
         end

         ST_RESP: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_addr_in   = res_addr_ff;
               rsp_cls_in    = res_cls_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         heap_base_ff   <= '0;
         chunk_limit_ff <= 9'd256;
         break_chunk_ff <= '0;
         carve_k_ff     <= '0;
         rsp_tvalid_ff  <= 1'b0;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            class_tops_ff[i] <= '0;
         end
      end else begin
         state_ff       <= state_in;
         heap_base_ff   <= heap_base_in;
         chunk_limit_ff <= chunk_limit_in;
         break_chunk_ff <= break_chunk_in;
         carve_k_ff     <= carve_k_in;
         rsp_tvalid_ff  <= rsp_tvalid_in;
         if (tops_we) begin
            class_tops_ff[tops_wr_idx] <= tops_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cls_ff        <= cls_in;
      unit_ff       <= unit_in;
      res_addr_ff   <= res_addr_in;
      res_cls_ff    <= res_cls_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_cls_ff    <= rsp_cls_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {4'd0, rsp_cls_ff, rsp_addr_ff};
   assign rsp_tuser  = rsp_status_ff;

   `SCPA_ASSERT_NEXT(a_one_item_in_flight, req_fire, !req_tready, "request taken while busy")
   `SCPA_ASSERT_NOW(a_carve_count_idle, state_ff != ST_CARVE, carve_k_ff == '0, "stray carve count")
   `SCPA_ASSERT_NOW(a_break_in_range, 1'b1, 16'(break_chunk_ff) <= 16'(HEAP_CHUNKS), "heap overrun")
   `SCPA_ASSERT_NEXT(a_rsp_from_resp, !rsp_tvalid_ff && state_ff != ST_RESP, !rsp_tvalid_ff, "stray beat")

endmodule
